// ===== hdl/mec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mec_pkg
// Shared widths and constants for the escape-time counter.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int COUNT_W    = 16;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(256);

    // |z|^2 > 4 in a (2*FRAC_BITS)-fraction-bit square; unreachable if 4 does not fit
    localparam int   THRESH_SH = 2 * FRAC_BITS + 2;
    localparam bit   ESC_EN    = (THRESH_SH < PROD_W);
    localparam logic [PROD_W-1:0] ESC_THRESH =
        ESC_EN ? (PROD_W'(1) << (ESC_EN ? THRESH_SH : 0)) : '0;

endpackage : mec_pkg
`default_nettype wire

// ===== hdl/mec_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mec_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mec_mul
    import mec_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [COORD_W-1:0] a,
    input  wire logic signed [COORD_W-1:0] b,
    output logic signed [PROD_W-1:0]       p
);

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    // signed operands are sign-extended to the 64-bit product width
    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule : mec_mul
`default_nettype wire

// ===== hdl/mandelbrot_escape_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter
// Escape-time count for one complex point c per transaction.
// ----------------------------------------------------------------------------
// One multiplier serves the whole z*z+c loop: each iteration steps through x*x,
// y*y, x*y, then test and update; a point that stays bounded is tested at most
// iteration_limit times (once when the limit is zero) before its result is valid.
// The input side is not ready while a point iterates. The result sits in an
// output register, so the next point may be accepted while it waits to be
// taken.
module mandelbrot_escape_counter
    import mec_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration: iteration_limit
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // [31:0] point_re, [63:32] point_im
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata,   // [15:0] escape_count
    output logic              m_tuser    // [0] inside_set
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_XX,
        S_YY,
        S_XY,
        S_TEST,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [COUNT_W-1:0]        limit_reg;
    logic [COUNT_W-1:0]        iter_reg;
    logic signed [COORD_W-1:0] cre_reg;
    logic signed [COORD_W-1:0] cim_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [PROD_W-1:0]  xx_reg;
    logic signed [PROD_W-1:0]  sq_reg;
    logic [PROD_W-1:0]         mag_reg;
    logic [COUNT_W-1:0]        res_count_reg;
    logic                      res_inside_reg;
    logic                      m_tvalid_reg;
    logic [COUNT_W-1:0]        m_count_reg;
    logic                      m_inside_reg;

    logic signed [COORD_W-1:0] mul_a;
    logic signed [COORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic signed [PROD_W-1:0]  sq_sh;
    logic signed [PROD_W-1:0]  xy_sh;
    logic signed [COORD_W-1:0] x_next;
    logic signed [COORD_W-1:0] y_next;
    logic                      escaped;
    logic                      out_free;

    // operand selection for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_XX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            S_YY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    mec_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // floor shifts; in S_TEST prod holds x*y
    assign sq_sh   = sq_reg >>> FRAC_BITS;
    assign xy_sh   = prod >>> (FRAC_BITS - 1);
    assign x_next  = sq_sh[COORD_W-1:0] + cre_reg;
    assign y_next  = xy_sh[COORD_W-1:0] + cim_reg;
    assign escaped = ESC_EN && (mag_reg > ESC_THRESH);

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            limit_reg    <= LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end

            // in S_DONE the output register is reloaded instead
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cre_reg   <= s_tdata[31:0];
                        cim_reg   <= s_tdata[63:32];
                        x_reg     <= s_tdata[31:0];
                        y_reg     <= s_tdata[63:32];
                        iter_reg  <= COUNT_W'(1);
                        state_reg <= S_XX;
                    end
                end
                S_XX:
                begin
                    state_reg <= S_YY;
                end
                S_YY:
                begin
                    xx_reg    <= prod;
                    state_reg <= S_XY;
                end
                S_XY:
                begin
                    // prod holds y*y here
                    sq_reg    <= xx_reg - prod;
                    mag_reg   <= PROD_W'(xx_reg) + PROD_W'(prod);
                    state_reg <= S_TEST;
                end
                S_TEST:
                begin
                    if (escaped)
                    begin
                        // a point outside on entry reports zero
                        res_count_reg  <= (iter_reg == COUNT_W'(1)) ? '0 : iter_reg;
                        res_inside_reg <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                    else if (iter_reg >= limit_reg)
                    begin
                        res_count_reg  <= '0;
                        res_inside_reg <= 1'b1;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        x_reg     <= x_next;
                        y_reg     <= y_next;
                        iter_reg  <= iter_reg + COUNT_W'(1);
                        state_reg <= S_XX;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_count_reg  <= res_count_reg;
                        m_inside_reg <= res_inside_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_count_reg;
    assign m_tuser  = m_inside_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a point is still iterating");

    a_inside_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("inside result with non-zero count");

    a_count_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata <= limit_reg)
        else $error("escape count beyond iteration limit");

    a_iter_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_XX && iter_reg != COUNT_W'(1) |-> iter_reg <= limit_reg)
        else $error("iteration counter ran past the limit");
`endif

endmodule : mandelbrot_escape_counter
`default_nettype wire

// ===== test/tb_mandelbrot_escape_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_counter
// Self-checking bench for the escape-time counter. Points go in over the
// input stream and every transaction is scored against an escape-time
// predictor that is run at the iteration limit in force when it was accepted.
// The bench covers fixed corner points, the extreme limits and long random
// runs, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_counter;
    import mec_pkg::*;

    typedef struct packed {
        logic [31:0]        point_re;
        logic [31:0]        point_im;
        logic [COUNT_W-1:0] count;
        logic               in_set;
    } escape_result_t;

    typedef enum int unsigned {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

    // 4.0 with 2*FRAC_BITS fraction bits
    localparam longint unsigned RADIUS_SQ = 64'd4 << (2 * FRAC_BITS);

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [15:0]        cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [63:0]        s_tdata     = '0;  // [31:0] point_re, [63:32] point_im
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [15:0]        m_tdata;           // [15:0] escape_count
    logic               m_tuser;           // [0] inside_set

    escape_result_t     expected_counts[$];
    logic [COUNT_W-1:0] limit_shadow = LIMIT_RESET;
    int unsigned        mismatches   = 0;
    int unsigned        burst_left   = 0;
    bit                 feeding      = 1'b0;

    rx_mode_t           rx_mode      = RX_OPEN;
    int unsigned        rx_span_left = 0;
    int unsigned        rx_tick      = 0;

    mandelbrot_escape_counter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit beyond_radius(input longint x, input longint y);
        longint unsigned mag;
        mag = x * x;
        mag = mag + y * y;
        return mag > RADIUS_SQ;
    endfunction

    function automatic escape_result_t escape_time(input logic [31:0] c_re,
                                                   input logic [31:0] c_im,
                                                   input logic [COUNT_W-1:0] limit);
        escape_result_t r;
        longint         x, y, sq, xy, re_shift, im_shift;
        logic [31:0]    z_re, z_im;
        int unsigned    i;
        r.point_re = c_re;
        r.point_im = c_im;
        r.count    = '0;
        r.in_set   = 1'b0;
        x = $signed(c_re);
        y = $signed(c_im);
        if (beyond_radius(x, y))
            return r;
        for (i = 1; i <= limit; i++)
        begin
            if (beyond_radius(x, y))
            begin
                r.count = i[COUNT_W-1:0];
                return r;
            end
            sq = x * x - y * y;
            xy = x * y;
            // arithmetic shift floors; the parts wrap at 32 bits
            re_shift = sq >>> FRAC_BITS;
            im_shift = xy >>> (FRAC_BITS - 1);
            z_re = re_shift[31:0] + c_re;
            z_im = im_shift[31:0] + c_im;
            x = $signed(z_re);
            y = $signed(z_im);
        end
        r.in_set = 1'b1;
        return r;
    endfunction

    // Caller is always sitting on a rising edge.
    task automatic issue_point(input logic [31:0] re, input logic [31:0] im);
        escape_result_t want;
        want = escape_time(re, im, limit_shadow);
        if (burst_left == 0)
        begin
            if (feeding)
                s_tvalid <= 1'b0;
            feeding = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        feeding = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_counts.insert(expected_counts.size(), want);
        burst_left--;
    endtask

    task automatic drain_results();
        if (feeding)
            s_tvalid <= 1'b0;
        feeding = 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called with nothing in flight.
    task automatic write_limit(input logic [COUNT_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_shadow = value;
    endtask

    // Corner points at the limit left by reset. Each entry is {im, re}.
    task automatic test_reset_limit_points();
        logic [63:0] corners [22] = '{
            {32'h0000_0000, 32'h0000_0000},   // origin
            {32'h0000_0000, 32'hE000_0000},   // -2: |z|^2 sits at exactly four
            {32'h0000_0000, 32'h2000_0000},   // +2: on the circle, out next step
            {32'h2000_0000, 32'h0000_0000},
            {32'hE000_0000, 32'h0000_0000},
            {32'h7FFF_FFFF, 32'h7FFF_FFFF},   // field extremes
            {32'h8000_0000, 32'h8000_0000},
            {32'h0000_0000, 32'h8000_0000},
            {32'h7FFF_FFFF, 32'h0000_0000},
            {32'h0000_0000, 32'hF000_0000},   // period two
            {32'h0000_0000, 32'h0400_0000},   // cusp, slow
            {32'h0000_0000, 32'h0428_F5C3},   // just past the cusp
            {32'h0199_999A, 32'hF400_0000},   // neck
            {32'h0800_0000, 32'h0800_0000},
            {32'h1000_0000, 32'h1000_0000},
            {32'h1000_0000, 32'h0000_0000},   // i, pre-periodic
            {32'h0A6A_7F00, 32'hFE66_6666},
            {32'hFFFF_FFFF, 32'h0000_0001},
            {32'h0000_0000, 32'h2000_0001},   // one lsb outside
            {32'h0000_0000, 32'hDFFF_FFFF},
            {32'h0000_0000, 32'hE800_0000},
            {32'h0800_0000, 32'h04CC_CCCD}
        };
        foreach (corners[k])
            issue_point(corners[k][31:0], corners[k][63:32]);
        drain_results();
    endtask

    task automatic test_limit_extremes();
        logic [31:0] mag;
        // no iterations at all: anything not already outside is inside
        write_limit(16'd0);
        issue_point(32'h0000_0000, 32'h0000_0000);
        issue_point(32'hE000_0000, 32'h0000_0000);
        issue_point(32'h2000_0000, 32'h0000_0000);
        issue_point(32'h3000_0000, 32'h0000_0000);
        drain_results();

        write_limit(16'd1);
        issue_point(32'h0000_0000, 32'h0000_0000);
        issue_point(32'h2000_0000, 32'h0000_0000);
        issue_point(32'h1000_0000, 32'h1000_0000);
        issue_point(32'h3000_0000, 32'hD000_0000);
        drain_results();

        // widest limit: quick escapers, then one full-length bounded point
        write_limit(16'hFFFF);
        issue_point(32'h0800_0000, 32'h0800_0000);
        issue_point(32'h1000_0000, 32'h0000_0000);
        issue_point(32'h0000_0000, 32'h2000_0000);
        repeat (6)
        begin
            mag = $urandom_range(32'h3000_0000, 32'h7FFF_FFFF);
            issue_point($urandom_range(0, 1) ? mag : -mag, $urandom);
        end
        issue_point(32'h0000_0000, 32'h0000_0000);
        drain_results();
    endtask

    task automatic test_random_points();
        int unsigned        pick, items;
        logic [31:0]        re, im, along, across;
        logic [COUNT_W-1:0] limit;
        for (int phase = 0; phase < 8; phase++)
        begin
            limit = (phase == 7) ? COUNT_W'($urandom_range(200, 320))
                                 : COUNT_W'($urandom_range(1, 64));
            items = (phase == 7) ? 60 : 190;
            write_limit(limit);
            for (int n = 0; n < items; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // box around the set
                    re = $urandom_range(0, 32'h3000_0000) - 32'h2400_0000;
                    im = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
                end
                else if (pick < 85)
                begin
                    // a few lsbs either side of the radius-two circle on an axis
                    along  = ($urandom_range(0, 1) ? 32'h2000_0000 : 32'hE000_0000)
                             + $urandom_range(0, 32) - 16;
                    across = $urandom_range(0, 32) - 16;
                    if ($urandom_range(0, 1))
                    begin
                        re = along;
                        im = across;
                    end
                    else
                    begin
                        re = across;
                        im = along;
                    end
                end
                else
                begin
                    re = $urandom;
                    im = $urandom;
                end
                issue_point(re, im);
                if (n == 100)
                    drain_results();
            end
            drain_results();
        end
    endtask

    always @(posedge clk)
    begin
        if (rx_span_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_span_left = $urandom_range(50, 300);
        end
        rx_span_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
            default:   m_tready <= (rx_tick % 5 == 0);
        endcase
    end

    always @(posedge clk)
    begin : score_result
        escape_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("%0t: unexpected result, escape_count %0d inside_set %0b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (m_tdata !== want.count)
                begin
                    $display("%0t: point (%h, %h) escape_count expected %0d got %0d",
                             $time, want.point_re, want.point_im, want.count, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.in_set)
                begin
                    $display("%0t: point (%h, %h) inside_set expected %0b got %0b",
                             $time, want.point_re, want.point_im, want.in_set, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_limit_points();
        test_limit_extremes();
        test_random_points();
        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_counts.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The bounded point at the widest limit alone runs for the full iteration limit.
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
